>>> hw/rtl/spdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spdh_pkg;

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 6;
    localparam int PAUSE_W    = 7;
    localparam int HIST_IDX_W = 6;
    localparam int COUNT_W    = 16;

    // Stream packing
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam int HISTORY_DEPTH_DEF = 64;

    // Bus decode constants
    localparam logic [ADDR_W-1:0]  TOGGLE_ADDR = 16'h0038;
    localparam logic [ADDR_W-1:0]  PAGE_MASK   = 16'hF000;
    localparam logic [ADDR_W-1:0]  STATUS_PAGE = 16'h1000;
    localparam logic [ADDR_W-1:0]  PITCH_PAGE  = 16'h3000;
    localparam logic [PAUSE_W-1:0] PAUSE_MAX   = 7'd127;
    localparam logic [PAUSE_W-1:0] STANDBY_PAUSE = 7'd2;
    localparam logic [CMD_W-1:0]   PAUSE_CMD_LAST = 6'd4;

    // Function codes of an input beat
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_STANDBY = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_HIST    = 3'd4;

    typedef struct packed {
        logic [HIST_IDX_W-1:0] history_index;
        logic                  chip_busy;
        logic [BYTE_W-1:0]     bus_byte;
        logic [ADDR_W-1:0]     addr;
        logic [FUNC_W-1:0]     func;
    } item_t;

    // Result of one beat before the history byte is merged in
    typedef struct packed {
        logic               claimed;
        logic [BYTE_W-1:0]  read_data;
        logic               rom_enabled;
        logic               command_strobe;
        logic [CMD_W-1:0]   command;
        logic               pitch_up;
        logic [COUNT_W-1:0] write_pointer;
        logic               hist_hit;
    } stage_t;

    // Pause length of commands 0 to 4
    function automatic logic [PAUSE_W-1:0] pause_len(input logic [2:0] c);
        logic [PAUSE_W-1:0] n;
        case (c)
            3'd0:    n = 7'd1;
            3'd1:    n = 7'd4;
            3'd2:    n = 7'd7;
            3'd3:    n = 7'd15;
            3'd4:    n = 7'd31;
            default: n = 7'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/speech_port_decoder_with_history_core.sv
// Channel | Dir | tdata (low bit up)                                  | tuser
// s_axis  | in  | addr[15:0] bus_byte[23:16] chip_busy[24]            | func[2:0]
//         |     | history_index[30:25], zero pad [31]                 |
// m_axis  | out | read_data[7:0] rom_enabled[8] command[14:9]         | claimed[0]
//         |     | pitch_up[15] write_pointer[31:16] history_entry[39:32] | command_strobe[1]
//
// One beat per cycle while the output takes beats; a command that logs a pending
// pause writes the history RAM twice and holds off the next beat, since the RAM
// has a single write port. A beat passes the RAM read, then the output register.
// Reset clears all control state; the history ring reads as zero until written,
// tracked by a fill level, so no clearing pass is needed.
// A stalled output holds its beat and backs up into the input after one more beat.
`timescale 1ns / 1ps
`default_nettype none

module speech_port_decoder_with_history_core #(
    parameter int HISTORY_DEPTH = spdh_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // addr, bus_byte, chip_busy, history_index, pad
    input  wire logic [spdh_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  wire logic [spdh_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // read_data, rom_enabled, command, pitch_up, write_pointer, history_entry
    output logic [spdh_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // claimed, command_strobe
    output logic [spdh_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    import spdh_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    item_t             in_item;
    stage_t            stage;
    logic              stage_load;
    logic              stage_ready;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Unpack input beat
    assign in_item.func          = s_axis_tuser;
    assign in_item.addr          = s_axis_tdata[15:0];
    assign in_item.bus_byte      = s_axis_tdata[23:16];
    assign in_item.chip_busy     = s_axis_tdata[24];
    assign in_item.history_index = s_axis_tdata[30:25];

    spdh_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_item     (in_item),
        .stage_ready (stage_ready),
        .stage_load  (stage_load),
        .stage       (stage),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    spdh_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spdh_outq u_outq (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_load    (stage_load),
        .stage_ready   (stage_ready),
        .stage         (stage),
        .ram_rdata     (ram_rdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> hw/rtl/spdh_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spdh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spdh_ctrl #(
    parameter int HISTORY_DEPTH = spdh_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire spdh_pkg::item_t                  in_item,
    input  wire logic                             stage_ready,
    output logic                                  stage_load,
    output spdh_pkg::stage_t                      stage,
    output logic                                  ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      ram_waddr,
    output logic [spdh_pkg::BYTE_W-1:0]           ram_wdata,
    output logic                                  ram_re,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      ram_raddr
);

    import spdh_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW:0]   FILL_FULL = (FW + 1)'(HISTORY_DEPTH);

    // State registers
    logic               enabled_reg, enabled_next;
    logic               pitch_reg, pitch_next;
    logic [PAUSE_W-1:0] pause_reg, pause_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic [BYTE_W-1:0]  pend_data_reg, pend_data_next;

    // Decode and update terms
    logic               fire;
    logic [ADDR_W-1:0]  page;
    logic               is_toggle;
    logic [CMD_W-1:0]   cmd;
    logic [PAUSE_W-1:0] pause_amt;
    logic               pause_add;
    logic [PAUSE_W:0]   pause_sum;
    logic [1:0]         nwrites;
    logic [BYTE_W-1:0]  wr1_data;
    logic [BYTE_W-1:0]  cmd_byte;
    logic [AW-1:0]      slot1, slot2;
    logic [COUNT_W-1:0] count_p1;
    logic [FW:0]        fill_sum;
    logic [AW-1:0]      idx_mod [2**HIST_IDX_W];

    // History index modulo depth, a constant table
    for (genvar gi = 0; gi < 2**HIST_IDX_W; gi++)
    begin : g_idx_mod
        assign idx_mod[gi] = AW'(gi % HISTORY_DEPTH);
    end

    // A second history write holds off the next beat while it is pending
    assign in_ready   = !pend_reg && stage_ready;
    assign fire       = in_valid && in_ready;
    assign stage_load = fire;

    assign page      = in_item.addr & PAGE_MASK;
    assign is_toggle = (in_item.func inside {FUNC_READ, FUNC_WRITE, FUNC_FETCH})
                       && (in_item.addr == TOGGLE_ADDR);
    assign cmd       = in_item.bus_byte[CMD_W-1:0];
    assign cmd_byte  = {1'b0, pitch_reg, cmd};
    assign pause_amt = (in_item.func == FUNC_STANDBY) ? STANDBY_PAUSE : pause_len(cmd[2:0]);
    assign pause_sum = {1'b0, pause_reg} + {1'b0, pause_amt};

    // Ring slot follows the write count modulo depth
    assign count_p1 = count_reg + 1'b1;
    assign slot1 = (count_reg == '1 || slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    assign slot2 = (count_p1 == '1 || slot1 == SLOT_LAST) ? '0 : slot1 + 1'b1;
    assign fill_sum = {1'b0, fill_reg} + (FW + 1)'(nwrites);

    // Beat decode
    always_comb
    begin
        enabled_next   = enabled_reg;
        pitch_next     = pitch_reg;
        pause_add      = 1'b0;
        pause_next     = pause_reg;
        nwrites        = 2'd0;
        wr1_data       = cmd_byte;
        pend_next      = 1'b0;
        pend_addr_next = slot1;
        pend_data_next = cmd_byte;
        stage          = '0;

        if (fire)
        begin
            if (is_toggle)
            begin
                enabled_next  = !enabled_reg;
                stage.claimed = 1'b1;
            end
            else
            begin
                case (in_item.func)
                    FUNC_READ:
                    begin
                        if (enabled_reg && page == STATUS_PAGE)
                        begin
                            stage.read_data = {in_item.bus_byte[BYTE_W-1:1], in_item.chip_busy};
                            stage.claimed   = 1'b1;
                        end
                    end
                    FUNC_WRITE:
                    begin
                        if (enabled_reg && page == STATUS_PAGE)
                        begin
                            stage.claimed        = 1'b1;
                            stage.command_strobe = 1'b1;
                            stage.command        = cmd;
                            if (cmd <= PAUSE_CMD_LAST)
                            begin
                                pause_add = 1'b1;
                            end
                            else if (pause_reg != '0)
                            begin
                                // log pending pause first, command follows next cycle
                                wr1_data   = {1'b1, pause_reg};
                                nwrites    = 2'd2;
                                pend_next  = 1'b1;
                                pause_next = '0;
                            end
                            else
                            begin
                                nwrites = 2'd1;
                            end
                        end
                        else if (enabled_reg && page == PITCH_PAGE)
                        begin
                            pitch_next    = in_item.addr[0];
                            stage.claimed = 1'b1;
                        end
                    end
                    FUNC_STANDBY:
                    begin
                        pause_add = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (pause_add)
        begin
            pause_next = (pause_sum > {1'b0, PAUSE_MAX}) ? PAUSE_MAX : pause_sum[PAUSE_W-1:0];
        end

        stage.rom_enabled   = enabled_next;
        stage.pitch_up      = pitch_next;
        stage.write_pointer = count_next;
        stage.hist_hit      = ram_re && ((fill_reg == FW'(HISTORY_DEPTH))
                                         || (FW'(ram_raddr) < fill_reg));
    end

    // Write count, ring slot and fill level
    always_comb
    begin
        case (nwrites)
            2'd1:
            begin
                count_next = count_p1;
                slot_next  = slot1;
            end
            2'd2:
            begin
                count_next = count_reg + 2'd2;
                slot_next  = slot2;
            end
            default:
            begin
                count_next = count_reg;
                slot_next  = slot_reg;
            end
        endcase
        fill_next = (fill_sum > FILL_FULL) ? FW'(HISTORY_DEPTH) : fill_sum[FW-1:0];
    end

    // Memory ports
    always_comb
    begin
        if (pend_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_data_reg;
        end
        else
        begin
            ram_we    = nwrites != 2'd0;
            ram_waddr = slot_reg;
            ram_wdata = wr1_data;
        end
    end

    assign ram_re    = fire && !is_toggle && (in_item.func == FUNC_HIST);
    assign ram_raddr = idx_mod[in_item.history_index];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            pitch_reg   <= 1'b0;
            pause_reg   <= '0;
            count_reg   <= '0;
            slot_reg    <= '0;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            enabled_reg <= enabled_next;
            pitch_reg   <= pitch_next;
            pause_reg   <= pause_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pend_addr_reg <= pend_addr_next;
            pend_data_reg <= pend_data_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spdh_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module spdh_outq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          stage_load,
    output logic                               stage_ready,
    input  wire spdh_pkg::stage_t              stage,
    input  wire logic [spdh_pkg::BYTE_W-1:0]   ram_rdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [spdh_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [spdh_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

    import spdh_pkg::*;

    logic              p1_valid_reg, p1_valid_next;
    stage_t            p1_reg;
    logic              m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;
    logic              advance;
    logic [BYTE_W-1:0] hist_byte;

    // Stage one waits for the memory read; output register parts the sides
    assign advance     = p1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign stage_ready = !p1_valid_reg || advance;
    assign hist_byte   = p1_reg.hist_hit ? ram_rdata : '0;

    always_comb
    begin
        p1_valid_next = stage_load ? 1'b1 : (advance ? 1'b0 : p1_valid_reg);
        m_valid_next  = advance ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
        m_data_next   = {hist_byte, p1_reg.write_pointer, p1_reg.pitch_up,
                         p1_reg.command, p1_reg.rom_enabled, p1_reg.read_data};
        m_user_next   = {p1_reg.command_strobe, p1_reg.claimed};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            p1_reg <= stage;
        end
        if (advance)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire
